// ----- rtl/core/frustum_plane_extract_and_cull_top_assert.svh -----
// Assertion macros for the frustum plane extract and cull block
`ifndef FRUSTUM_PLANE_EXTRACT_AND_CULL_TOP_ASSERT_SVH
`define FRUSTUM_PLANE_EXTRACT_AND_CULL_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define FPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frustum cull assertion failed");
// next-cycle implication
`define FPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frustum cull assertion failed");
`else
`define FPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/fpc_pkg.sv -----
// Shared types, codes and helpers of the frustum plane extract and cull block
package fpc_pkg;
	localparam int NUM_PLANES = 6;
	localparam int ACC_W = 66;

	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_EXTRACT = 3'd1,
		OP_POINT   = 3'd2,
		OP_SPHERE  = 3'd3,
		OP_VERTEX  = 3'd4
	} fpc_op_t;

	typedef enum logic [1:0] {
		ANS_EXTRACT = 2'd0,
		ANS_TEST    = 2'd1,
		ANS_SET     = 2'd2
	} fpc_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CL_RDA,
		ST_CL_RDB,
		ST_CL_MUL,
		ST_CL_ACC,
		ST_CL_WR,
		ST_PL_RDW,
		ST_PL_RDE,
		ST_PL_RAW,
		ST_PL_SQ,
		ST_PL_SQACC,
		ST_PL_RSTART,
		ST_PL_RWAIT,
		ST_PL_ZERO,
		ST_PL_DSTART,
		ST_PL_DWAIT,
		ST_TS_RUN
	} fpc_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fpc_iter_stat_t;

	// clip column used by each plane: x for right/left, y for bottom/top, z for far/near
	function automatic logic [1:0] plane_axis(input logic [2:0] p);
		logic [1:0] a;
		case (p)
			3'd0, 3'd1: a = 2'd0;
			3'd2, 3'd3: a = 2'd1;
			default:    a = 2'd2;
		endcase
		return a;
	endfunction

	// planes formed as w - e: right, top, far
	function automatic logic plane_neg(input logic [2:0] p);
		return (p == 3'd0) || (p == 3'd3) || (p == 3'd4);
	endfunction

	// clamp a wide signed value to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]))
			r = v[31:0];
		else if (v[ACC_W-1])
			r = 32'sh8000_0000;
		else
			r = 32'sh7fff_ffff;
		return r;
	endfunction
endpackage

// ----- rtl/core/fpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module fpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/fpc_isqrt.sv -----
// Iterative 64-bit integer square root, one result bit per cycle
module fpc_isqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [63:0]             radicand,
	output logic [31:0]             root,
	output fpc_pkg::fpc_iter_stat_t stat
);
	import fpc_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  shamt;
	logic [63:0] bit_w;
	logic [64:0] trial;
	logic        take;

	// trial bit walks from 2^62 down to 2^0 two places a step
	assign shamt = 6'd62 - {cnt_q, 1'b0};
	assign bit_w = 64'd1 << shamt;
	assign trial = {1'b0, res_q} + {1'b0, bit_w};
	assign take  = {1'b0, rem_q} >= trial;

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and root update
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - trial[63:0];
				res_q <= (res_q >> 1) + bit_w;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign root      = res_q[31:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ----- rtl/core/fpc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle
module fpc_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output logic [NUM_W-1:0]        quo,
	output fpc_pkg::fpc_iter_stat_t stat
);
	import fpc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] sh_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_ext;
	logic             take;
	logic [DEN_W:0]   rem_sub;

	// shift in the next dividend bit and try the subtract
	assign rem_ext = {rem_q, sh_q[NUM_W-1]};
	assign take    = rem_ext >= {1'b0, den_q};
	assign rem_sub = rem_ext - {1'b0, den_q};

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NUM_W-2:0], take};
			rem_q <= take ? rem_sub[DEN_W-1:0] : rem_ext[DEN_W-1:0];
		end
	end

	assign quo       = sh_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ----- rtl/core/frustum_plane_extract_and_cull_top.sv -----
// Top level: frustum plane extraction from stored matrices and plane culling tests
//
//  channel   signals                                   direction  handshake
//  command   start/busy, op .. last_vertex             in         start & !busy
//  config    cfg_valid/cfg_ready, cfg_data             in         valid & ready
//  result    result_valid, answer_kind/visible/degen.  out        one-cycle strobe
//
// Load writes one matrix element; point and sphere tests walk all six planes and
// a vertex SET_PLANES, one coefficient at a time through the one read port of the
// plane memory feeding one MAC. In extraction the matrix memory gives one operand
// a cycle, and root and divide units give one bit a cycle.
// Reset clears control, margin (to 7) and hit bits; planes read zero until the
// first extraction. Results cannot be stalled: each strobe lasts one cycle.
`include "frustum_plane_extract_and_cull_top_assert.svh"
module frustum_plane_extract_and_cull_top #(
	parameter int FRAC_BITS  = 16,
	parameter int SET_PLANES = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic               matrix_select,
	input  logic [3:0]         element_index,
	input  logic signed [31:0] element_value,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic [30:0]        radius,
	input  logic               last_vertex,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output logic               result_valid,
	output logic [1:0]         answer_kind,
	output logic               visible,
	output logic               degenerate
);
	import fpc_pkg::*;

	localparam int NUM_W = 33 + FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [33:0] LIM = 34'sd1 <<< FRAC_BITS;
	localparam logic [NUM_W-1:0] QMAX = NUM_W'(1) << 31;
	localparam logic [SET_PLANES-1:0] SET_FULL = {SET_PLANES{1'b1}};
	localparam logic [4:0] TOT_TEST = 5'(4 * NUM_PLANES);
	localparam logic [4:0] TOT_SET = 5'(4 * SET_PLANES);
	localparam logic [2:0] LAST_TEST = 3'(NUM_PLANES - 1);
	localparam logic [2:0] LAST_SET = 3'(SET_PLANES - 1);

	fpc_state_t state_q, state_d;
	logic accept;

	// memories
	logic              m_we;
	logic [5:0]        m_waddr, m_raddr;
	logic [31:0]       m_wdata, m_rdata;
	logic              p_we;
	logic [4:0]        p_waddr, p_raddr;
	logic [31:0]       p_wdata, p_rdata;

	// sequencer and datapath registers
	logic [3:0]               ij_q;
	logic [1:0]               k_q;
	logic [2:0]               p_q;
	logic signed [31:0]       a_q;
	logic signed [31:0]       raw_q [4];
	logic signed [63:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [63:0]              sq_q;
	logic [31:0]              len_q;
	logic                     deg_q;
	logic [15:0]              margin_q;
	logic                     planes_valid_q;

	logic [2:0]               op_q;
	logic                     last_q;
	logic signed [31:0]       px_q, py_q, pz_q;
	logic signed [ACC_W-1:0]  bound_q;
	logic [4:0]               issue_q;
	logic                     v_s1, v_s2;
	logic [1:0]               k_s1, k_s2;
	logic [2:0]               p_s1, p_s2;
	logic signed [ACC_W-1:0]  dist_q;
	logic                     allv_q;
	logic [SET_PLANES-1:0]    hit_q;

	logic                     res_valid_q;
	fpc_kind_t                kind_q;
	logic                     vis_q;
	logic                     deg_out_q;

	// combinational datapath
	logic signed [31:0]       mul_a, mul_b;
	logic signed [ACC_W-1:0]  prod_ext, clip_term;
	logic signed [32:0]       w_ext, e_ext, raw_sum;
	logic signed [31:0]       raw_sat, raw_cur;
	logic [31:0]              raw_mag;
	logic [NUM_W-1:0]         div_num, div_quo;
	logic [32:0]              q_cl;
	logic signed [33:0]       v_sgn, v_lim;
	logic signed [31:0]       coef_val;
	logic [63:0]              sq_root_in;
	logic [31:0]              root;
	logic                     sq_start, div_start;
	fpc_iter_stat_t           sq_stat, div_stat;
	logic signed [31:0]       coef, oper;
	logic signed [ACC_W-1:0]  dist_base, dist_sum;
	logic                     above, done_plane, last_plane, test_finish, issuing;
	logic [SET_PLANES-1:0]    plane_mask, hit_next;
	logic [4:0]               test_total;
	logic                     ext_end;
	logic                     plane_step;
	logic [31:0]              bsum;
	logic signed [ACC_W-1:0]  bound_d;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	fpc_ram #(.WIDTH(32), .DEPTH(48)) u_mat_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	fpc_ram #(.WIDTH(32), .DEPTH(4 * NUM_PLANES)) u_plane_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	assign sq_root_in = sq_q;

	fpc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_root_in),
		.root     (root),
		.stat     (sq_stat)
	);

	fpc_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (len_q),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// clip product rounding
	assign prod_ext  = ACC_W'(prod_q);
	assign clip_term = (prod_ext + HALF) >>> FRAC_BITS;

	// raw plane coefficient from w and the axis element
	assign w_ext   = 33'(a_q);
	assign e_ext   = 33'($signed(m_rdata));
	assign raw_sum = plane_neg(p_q) ? (w_ext - e_ext) : (w_ext + e_ext);
	assign raw_sat = sat32(ACC_W'(raw_sum));

	// normalize one coefficient by the normal length
	assign raw_cur = raw_q[k_q];
	assign raw_mag = raw_cur[31] ? (~raw_cur + 32'd1) : raw_cur;
	assign div_num = (NUM_W'(raw_mag) << FRAC_BITS) + NUM_W'(len_q >> 1);
	assign q_cl    = (div_quo > QMAX) ? 33'(QMAX) : div_quo[32:0];
	assign v_sgn   = raw_cur[31] ? -$signed({1'b0, q_cl}) : $signed({1'b0, q_cl});

	always_comb begin
		v_lim = v_sgn;
		if (k_q != 2'd3) begin
			if (v_sgn > LIM)
				v_lim = LIM;
			else if (v_sgn < -LIM)
				v_lim = -LIM;
		end
	end

	assign coef_val = sat32(ACC_W'(v_lim));

	// plane distance pipeline
	assign coef = planes_valid_q ? $signed(p_rdata) : 32'sd0;

	always_comb begin
		case (k_s1)
			2'd0:    oper = px_q;
			2'd1:    oper = py_q;
			2'd2:    oper = pz_q;
			default: oper = ONE;
		endcase
	end

	assign dist_base   = (k_s2 == 2'd0) ? ACC_W'(0) : dist_q;
	assign dist_sum    = dist_base + prod_ext;
	assign above       = dist_sum > bound_q;
	assign done_plane  = v_s2 && (k_s2 == 2'd3);
	assign last_plane  = p_s2 == ((op_q == OP_VERTEX) ? LAST_SET : LAST_TEST);
	assign test_finish = (state_q == ST_TS_RUN) && done_plane && last_plane;
	assign plane_mask  = above ? (SET_PLANES'(1) << p_s2) : '0;
	assign hit_next    = hit_q | plane_mask;
	assign test_total  = (op_q == OP_VERTEX) ? TOT_SET : TOT_TEST;
	assign issuing     = issue_q < test_total;

	// last coefficient of the last plane written
	assign plane_step = (state_q == ST_PL_ZERO) || ((state_q == ST_PL_DWAIT) && div_stat.done);
	assign ext_end    = plane_step && (k_q == 2'd3) && (p_q == LAST_TEST);

	// test bound from margin and radius
	assign bsum    = 32'(margin_q) + ((op == OP_SPHERE) ? 32'(radius) : 32'd0);
	assign bound_d = -($signed({{(ACC_W - 32){1'b0}}, bsum}) <<< FRAC_BITS);

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state, memory ports and multiplier operands
	always_comb begin
		state_d   = state_q;
		m_we      = 1'b0;
		m_waddr   = {1'b0, matrix_select, element_index};
		m_wdata   = element_value;
		m_raddr   = '0;
		p_we      = 1'b0;
		p_waddr   = {p_q, k_q};
		p_wdata   = '0;
		p_raddr   = issuing ? issue_q : '0;
		mul_a     = '0;
		mul_b     = '0;
		sq_start  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_LOAD:    m_we = 1'b1;
						OP_EXTRACT: state_d = ST_CL_RDA;
						OP_POINT, OP_SPHERE, OP_VERTEX: state_d = ST_TS_RUN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CL_RDA: begin
				m_raddr = {2'b00, ij_q[3:2], k_q};
				state_d = ST_CL_RDB;
			end
			ST_CL_RDB: begin
				m_raddr = {2'b01, k_q, ij_q[1:0]};
				state_d = ST_CL_MUL;
			end
			ST_CL_MUL: begin
				mul_a   = a_q;
				mul_b   = $signed(m_rdata);
				state_d = ST_CL_ACC;
			end
			ST_CL_ACC: begin
				state_d = (k_q == 2'd3) ? ST_CL_WR : ST_CL_RDA;
			end
			ST_CL_WR: begin
				m_we    = 1'b1;
				m_waddr = {2'b10, ij_q};
				m_wdata = sat32(acc_q);
				state_d = (ij_q == 4'd15) ? ST_PL_RDW : ST_CL_RDA;
			end
			ST_PL_RDW: begin
				m_raddr = {2'b10, k_q, 2'b11};
				state_d = ST_PL_RDE;
			end
			ST_PL_RDE: begin
				m_raddr = {2'b10, k_q, plane_axis(p_q)};
				state_d = ST_PL_RAW;
			end
			ST_PL_RAW: begin
				state_d = (k_q == 2'd3) ? ST_PL_SQ : ST_PL_RDW;
			end
			ST_PL_SQ: begin
				mul_a   = raw_cur;
				mul_b   = raw_cur;
				state_d = ST_PL_SQACC;
			end
			ST_PL_SQACC: begin
				state_d = (k_q == 2'd2) ? ST_PL_RSTART : ST_PL_SQ;
			end
			ST_PL_RSTART: begin
				sq_start = 1'b1;
				state_d  = ST_PL_RWAIT;
			end
			ST_PL_RWAIT: begin
				if (sq_stat.done)
					state_d = (root == 32'd0) ? ST_PL_ZERO : ST_PL_DSTART;
			end
			ST_PL_ZERO: begin
				p_we = 1'b1;
				if (k_q == 2'd3)
					state_d = (p_q == LAST_TEST) ? ST_IDLE : ST_PL_RDW;
			end
			ST_PL_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_PL_DWAIT;
			end
			ST_PL_DWAIT: begin
				if (div_stat.done) begin
					p_we    = 1'b1;
					p_wdata = coef_val;
					if (k_q == 2'd3)
						state_d = (p_q == LAST_TEST) ? ST_IDLE : ST_PL_RDW;
					else
						state_d = ST_PL_DSTART;
				end
			end
			ST_TS_RUN: begin
				mul_a = coef;
				mul_b = oper;
				if (test_finish)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers: counters, stage valids, hit bits, margin, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ij_q           <= '0;
			k_q            <= '0;
			p_q            <= '0;
			issue_q        <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			hit_q          <= '0;
			margin_q       <= 16'd7;
			planes_valid_q <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= v_s1;
			if (cfg_valid && cfg_ready)
				margin_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ij_q    <= '0;
						k_q     <= '0;
						p_q     <= '0;
						issue_q <= '0;
					end
				end
				ST_CL_ACC:   k_q  <= k_q + 2'd1;
				ST_CL_WR:    ij_q <= ij_q + 4'd1;
				ST_PL_RAW:   k_q  <= k_q + 2'd1;
				ST_PL_SQACC: k_q  <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				ST_PL_ZERO, ST_PL_DWAIT: begin
					if (plane_step) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3)
							p_q <= p_q + 3'd1;
					end
				end
				ST_TS_RUN: begin
					if (issuing) begin
						issue_q <= issue_q + 5'd1;
						v_s1    <= 1'b1;
					end
					if (done_plane && (op_q == OP_VERTEX))
						hit_q <= (test_finish && last_q) ? '0 : hit_next;
					if (test_finish && ((op_q != OP_VERTEX) || last_q))
						res_valid_q <= 1'b1;
				end
				default: ;
			endcase
			if (ext_end) begin
				planes_valid_q <= 1'b1;
				res_valid_q    <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		k_s1   <= issue_q[1:0];
		p_s1   <= issue_q[4:2];
		k_s2   <= k_s1;
		p_s2   <= p_s1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q    <= op;
					last_q  <= last_vertex;
					px_q    <= px;
					py_q    <= py;
					pz_q    <= pz;
					bound_q <= bound_d;
					acc_q   <= '0;
					sq_q    <= '0;
					allv_q  <= 1'b1;
					if (op == OP_EXTRACT)
						deg_q <= 1'b0;
				end
			end
			ST_CL_RDB:   a_q   <= $signed(m_rdata);
			ST_CL_ACC:   acc_q <= acc_q + clip_term;
			ST_CL_WR:    acc_q <= '0;
			ST_PL_RDE:   a_q   <= $signed(m_rdata);
			ST_PL_RAW:   raw_q[k_q] <= raw_sat;
			ST_PL_SQACC: sq_q  <= sq_q + 64'(prod_q);
			ST_PL_RWAIT: begin
				if (sq_stat.done) begin
					len_q <= root;
					if (root == 32'd0)
						deg_q <= 1'b1;
				end
			end
			ST_PL_ZERO, ST_PL_DWAIT: begin
				if (plane_step && (k_q == 2'd3))
					sq_q <= '0;
			end
			ST_TS_RUN: begin
				if (v_s2)
					dist_q <= dist_sum;
				if (done_plane)
					allv_q <= allv_q && above;
			end
			default: ;
		endcase
		// capture result fields
		if (ext_end) begin
			kind_q    <= ANS_EXTRACT;
			vis_q     <= 1'b0;
			deg_out_q <= deg_q;
		end else if (test_finish) begin
			kind_q    <= (op_q == OP_VERTEX) ? ANS_SET : ANS_TEST;
			vis_q     <= (op_q == OP_VERTEX) ? (hit_next == SET_FULL) : (allv_q && above);
			deg_out_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign answer_kind  = kind_q;
	assign visible      = vis_q;
	assign degenerate   = deg_out_q;

	`FPC_ASSERT_IMP(a_result_after_work, clk, arst_n, res_valid_q, $past(busy))
	`FPC_ASSERT_IMP(a_root_start_idle, clk, arst_n, sq_start, !sq_stat.busy)
	`FPC_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_start, !div_stat.busy)
	`FPC_ASSERT_NXT(a_extract_busy, clk, arst_n, accept && (op == OP_EXTRACT), busy)
	`FPC_ASSERT_IMP(a_stage_in_test, clk, arst_n, v_s2, state_q == ST_TS_RUN)
endmodule
